// ===== hdl/orthogonal_range_count_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the orthogonal range count unit
// Shared check forms, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef ORTHOGONAL_RANGE_COUNT_UNIT_DEFINES_SVH
`define ORTHOGONAL_RANGE_COUNT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ORC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ORC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/orc_pkg.sv =====
// ----------------------------------------------------------------------------
// orc_pkg
// Shared types and constants of the orthogonal range count unit.
// ----------------------------------------------------------------------------
package orc_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_MAX_DEF  = 100000;

  localparam int COORD_W = 17;
  localparam int HIT_W   = 11;
  localparam int TOTAL_W = 32;
  localparam int HIT_MAX = 2047;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // Command moving down the cell chain. For an insert the point sits in a (x)
  // and c (y); for a query a..d are left, right, bottom, top.
  typedef struct packed {
    logic               valid;
    cmd_e               kind;
    logic               rej;
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] d;
  } op_t;

endpackage

// ===== hdl/orc_cell.sv =====
// ----------------------------------------------------------------------------
// orc_cell
// One point slot of the chain: stores its point, counts it for passing queries.
// ----------------------------------------------------------------------------
module orc_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  orc_pkg::op_t      op_in,
  input  logic [IDX_W-1:0]  idx_in,
  input  logic [IDX_W-1:0]  cnt_in,
  output orc_pkg::op_t      op_out,
  output logic [IDX_W-1:0]  idx_out,
  output logic [IDX_W-1:0]  cnt_out
);

  logic [orc_pkg::COORD_W-1:0] px;
  logic [orc_pkg::COORD_W-1:0] py;
  logic                        is_mine;
  logic                        hit;

  // idx is the insert slot for inserts, the live point count for queries
  assign is_mine = (idx_in == IDX_W'(INDEX));
  assign hit = op_in.valid && (op_in.kind == orc_pkg::CMD_QUERY) &&
               (IDX_W'(INDEX) < idx_in) &&
               (px >= op_in.a) && (px <= op_in.b) &&
               (py >= op_in.c) && (py <= op_in.d);

  always_ff @(posedge clk) begin
    if (en && op_in.valid && (op_in.kind == orc_pkg::CMD_INSERT) && is_mine) begin
      px <= op_in.a;
      py <= op_in.c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_out.valid <= 1'b0;
    end else if (en) begin
      op_out  <= op_in;
      idx_out <= idx_in;
      cnt_out <= cnt_in + IDX_W'(hit);
    end
  end

endmodule

// ===== hdl/orc_total.sv =====
// ----------------------------------------------------------------------------
// orc_total
// Chain exit: saturating running total and the registered result.
// ----------------------------------------------------------------------------
module orc_total #(
  parameter int CNT_W = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  orc_pkg::op_t                 op_in,
  input  logic [CNT_W-1:0]             cnt_in,
  output logic                         res_valid,
  output logic                         res_status,
  output logic [orc_pkg::HIT_W-1:0]    res_hit,
  output logic [orc_pkg::TOTAL_W-1:0]  res_total
);

  logic [orc_pkg::TOTAL_W-1:0] total;
  logic [orc_pkg::TOTAL_W-1:0] total_next;
  logic [orc_pkg::TOTAL_W-1:0] cnt_ext;
  logic [orc_pkg::TOTAL_W:0]   sum;
  logic                        is_query;
  logic                        is_rej;

  assign cnt_ext  = orc_pkg::TOTAL_W'(cnt_in);
  assign sum      = {1'b0, total} + {1'b0, cnt_ext};
  assign is_query = op_in.valid && (op_in.kind == orc_pkg::CMD_QUERY);
  assign is_rej   = op_in.valid && (op_in.kind == orc_pkg::CMD_INSERT) && op_in.rej;

  always_comb begin
    total_next = total;
    if (op_in.valid && (op_in.kind == orc_pkg::CMD_CLEAR)) begin
      total_next = '0;
    end else if (is_query) begin
      total_next = sum[orc_pkg::TOTAL_W] ? '1 : sum[orc_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      total     <= total_next;
      res_valid <= is_query || is_rej;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_status <= is_rej;
      res_total  <= total_next;
      if (is_rej) begin
        res_hit <= '0;
      end else if (cnt_ext > orc_pkg::TOTAL_W'(orc_pkg::HIT_MAX)) begin
        res_hit <= orc_pkg::HIT_W'(orc_pkg::HIT_MAX);
      end else begin
        res_hit <= cnt_ext[orc_pkg::HIT_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/orthogonal_range_count_unit.sv =====
// ----------------------------------------------------------------------------
// orthogonal_range_count_unit
// 2-D point store with inclusive rectangle counting, built as a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                        | tuser
//  --------+-----+-------------------------------------------+----------------
//  s_*     | in  | point_x, point_y, rect_left, rect_right,  | cmd (2 bits)
//          |     | rect_bottom, rect_top (17 b each), 2 pad  |
//  m_*     | out | hit_count (11 b), running_total (32 b),   | status (1 bit)
//          |     | 5 pad                                     |
//
//  One transfer is taken per cycle while the output is not stalled; every
//  command walks the full chain, so a result passes through the register of
//  every cell and then the total stage before it leaves.
//  Reset is synchronous; stored points need no clearing, the point count gates
//  which cells take part.
//  A stalled output freezes the whole chain and drops s_tready in the same
//  cycle; nothing inside moves until m_tready frees the output register.
//
// ----------------------------------------------------------------------------
`include "orthogonal_range_count_unit_defines.svh"

module orthogonal_range_count_unit #(
  parameter int MAX_POINTS = orc_pkg::MAX_POINTS_DEF,
  parameter int COORD_MAX  = orc_pkg::COORD_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x[16:0], point_y[33:17], rect_left[50:34], rect_right[67:51],
  // rect_bottom[84:68], rect_top[101:85], zero pad[103:102]
  input  logic [103:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_count[10:0], running_total[42:11], zero pad[47:43]
  output logic [47:0]  m_tdata,
  // status[0]
  output logic [0:0]   m_tuser
);

  localparam int CW    = orc_pkg::COORD_W;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // Saturate a raw coordinate at COORD_MAX (no effect once COORD_MAX is past
  // the field range).
  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
    logic [20:0] wide;
    begin
      wide = {4'b0, v};
      clamp = (wide > 21'(COORD_MAX)) ? CW'(COORD_MAX) : v;
    end
  endfunction

  logic                         advance;
  logic                         accept;
  orc_pkg::cmd_e                cmd;
  logic [CW-1:0]                px, py, rl, rr, rb, rt;
  logic                         empty_rect;
  logic                         full;
  logic [CNT_W-1:0]             point_count;
  logic [CNT_W-1:0]             point_count_next;

  orc_pkg::op_t                 chain_op  [0:MAX_POINTS];
  logic [CNT_W-1:0]             chain_idx [0:MAX_POINTS];
  logic [CNT_W-1:0]             chain_cnt [0:MAX_POINTS];

  logic                         res_status;
  logic [orc_pkg::HIT_W-1:0]    res_hit;
  logic [orc_pkg::TOTAL_W-1:0]  res_total;

  // Whole chain steps together whenever the output register can move.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  assign cmd = orc_pkg::cmd_e'(s_tuser);
  assign px  = clamp(s_tdata[16:0]);
  assign py  = clamp(s_tdata[33:17]);
  assign rl  = clamp(s_tdata[50:34]);
  assign rr  = clamp(s_tdata[67:51]);
  assign rb  = clamp(s_tdata[84:68]);
  assign rt  = clamp(s_tdata[101:85]);

  assign empty_rect = (rl > rr) || (rb > rt);
  assign full       = (point_count >= CNT_W'(MAX_POINTS));

  // Entry formatting: insert gets its slot, query gets the live count
  // (zero for an empty rectangle so no cell matches).
  always_comb begin
    chain_op[0]       = '0;
    chain_op[0].kind  = cmd;
    chain_idx[0]      = point_count;
    chain_cnt[0]      = '0;
    point_count_next  = point_count;
    unique case (cmd)
      orc_pkg::CMD_CLEAR: begin
        chain_op[0].valid = s_tvalid;
        point_count_next  = '0;
      end
      orc_pkg::CMD_INSERT: begin
        chain_op[0].valid = s_tvalid;
        chain_op[0].rej   = full;
        chain_op[0].a     = px;
        chain_op[0].c     = py;
        if (!full) begin
          point_count_next = point_count + CNT_W'(1);
        end
      end
      orc_pkg::CMD_QUERY: begin
        chain_op[0].valid = s_tvalid;
        chain_op[0].a     = rl;
        chain_op[0].b     = rr;
        chain_op[0].c     = rb;
        chain_op[0].d     = rt;
        if (empty_rect) begin
          chain_idx[0] = '0;
        end
      end
      default: begin
        chain_op[0].valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (accept) begin
      point_count <= point_count_next;
    end
  end

  // One cell per point slot.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    orc_cell #(
      .INDEX (i),
      .IDX_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .op_in   (chain_op[i]),
      .idx_in  (chain_idx[i]),
      .cnt_in  (chain_cnt[i]),
      .op_out  (chain_op[i+1]),
      .idx_out (chain_idx[i+1]),
      .cnt_out (chain_cnt[i+1])
    );
  end

  orc_total #(
    .CNT_W (CNT_W)
  ) u_total (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .op_in      (chain_op[MAX_POINTS]),
    .cnt_in     (chain_cnt[MAX_POINTS]),
    .res_valid  (m_tvalid),
    .res_status (res_status),
    .res_hit    (res_hit),
    .res_total  (res_total)
  );

  assign m_tdata = {5'b0, res_total, res_hit};
  assign m_tuser = res_status;

  // Checks
  `ORC_ASSERT_NOW(a_count_bound, 1'b1, point_count <= CNT_W'(MAX_POINTS), "point count overrun")
  `ORC_ASSERT_NEXT(a_clear_empties, accept && (s_tuser == orc_pkg::CMD_CLEAR), point_count == '0, "clear left points")
  `ORC_ASSERT_NEXT(a_insert_grows, accept && (s_tuser == orc_pkg::CMD_INSERT) && !full, point_count == $past(point_count) + CNT_W'(1), "insert not counted")
  `ORC_ASSERT_NOW(a_reject_zero, m_tvalid && m_tuser[0], m_tdata[10:0] == '0, "reject with nonzero count")

endmodule
